>>> rtl/tafr_pkg.sv
// shared types, constants and helper functions for the telemetry ascii framer
// no dependencies; compiled before every other file of the block
`timescale 1ns / 1ps

package tafr_pkg;

  localparam int VAL_W      = 16;
  localparam int NUM_VALS   = 4;
  localparam int DEC_DIGITS = 5;
  localparam int BCD_W      = DEC_DIGITS * 4;
  localparam int CHAR_W     = 7;
  localparam int FRAME_LEN  = 40;
  localparam int POS_W      = $clog2(FRAME_LEN);
  localparam int CONV_W     = $clog2(VAL_W);
  localparam int VIDX_W     = $clog2(NUM_VALS);
  localparam int DIG_W      = $clog2(DEC_DIGITS);

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [BCD_W-1:0]  bcd_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [CONV_W-1:0] conv_cnt_t;

  localparam pos_t      POS_LAST  = pos_t'(FRAME_LEN - 1);
  localparam conv_cnt_t CONV_LAST = conv_cnt_t'(VAL_W - 1);

  // ascii codes used in the frame
  localparam char_t CH_LT    = 7'h3C;
  localparam char_t CH_GT    = 7'h3E;
  localparam char_t CH_BAR   = 7'h7C;
  localparam char_t CH_COMMA = 7'h2C;
  localparam char_t CH_CR    = 7'h0D;
  localparam char_t CH_LF    = 7'h0A;
  localparam char_t CH_0     = 7'h30;
  localparam char_t CH_A     = 7'h41;
  localparam char_t CH_T     = 7'h54;
  localparam char_t CH_H     = 7'h48;
  localparam char_t CH_R     = 7'h52;
  localparam char_t CH_L     = 7'h4C;
  localparam char_t CH_X     = 7'h58;
  localparam char_t CH_G     = 7'h47;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SLOT_LIT,
    SLOT_DIG,
    SLOT_CSH,
    SLOT_CSL
  } slot_kind_t;

  typedef struct packed {
    slot_kind_t          kind;
    char_t               lit;
    logic [VIDX_W-1:0]   val_idx;
    logic [DIG_W-1:0]    dig_idx;
    logic                body;
  } slot_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_step;
    pos_t pos;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // frame template: one slot per position, digit slots may be skipped
  function automatic slot_t slot_info(pos_t pos);
    slot_t s;
    pos_t  d;
    s.kind    = SLOT_LIT;
    s.lit     = CH_LF;
    s.val_idx = '0;
    s.dig_idx = '0;
    s.body    = (pos >= pos_t'(1)) && (pos <= pos_t'(33));
    d         = '0;
    case (pos) inside
      0:                   s.lit = CH_LT;
      1:                   s.lit = CH_T;
      [2:6]: begin
        s.kind    = SLOT_DIG;
        s.val_idx = VIDX_W'(0);
        d         = pos - pos_t'(2);
      end
      7, 14, 21, 24, 27:   s.lit = CH_COMMA;
      8:                   s.lit = CH_H;
      [9:13]: begin
        s.kind    = SLOT_DIG;
        s.val_idx = VIDX_W'(1);
        d         = pos - pos_t'(9);
      end
      15:                  s.lit = CH_R;
      [16:20]: begin
        s.kind    = SLOT_DIG;
        s.val_idx = VIDX_W'(2);
        d         = pos - pos_t'(16);
      end
      22:                  s.lit = CH_L;
      23, 26:              s.lit = CH_0;
      25:                  s.lit = CH_X;
      28:                  s.lit = CH_G;
      [29:33]: begin
        s.kind    = SLOT_DIG;
        s.val_idx = VIDX_W'(3);
        d         = pos - pos_t'(29);
      end
      34:                  s.lit = CH_BAR;
      35:                  s.kind = SLOT_CSH;
      36:                  s.kind = SLOT_CSL;
      37:                  s.lit = CH_GT;
      38:                  s.lit = CH_CR;
      default:             s.lit = CH_LF;
    endcase
    s.dig_idx = d[DIG_W-1:0];
    return s;
  endfunction

  // uppercase hex digit
  function automatic char_t hex_char(logic [3:0] n);
    char_t c;
    if (n < 4'd10) begin
      c = CH_0 + char_t'(n);
    end else begin
      c = CH_A + char_t'(n - 4'd10);
    end
    return c;
  endfunction

endpackage

>>> rtl/tafr_in_if.sv
// request channel: valid/ready handshake with four 16-bit sensor readings
// depends on tafr_pkg
`timescale 1ns / 1ps

interface tafr_in_if;
  import tafr_pkg::*;

  logic valid;
  logic ready;
  val_t temperature_tenths;
  val_t humidity_tenths;
  val_t rear_distance_cm;
  val_t gas_reading;

  modport source (
    output valid, temperature_tenths, humidity_tenths, rear_distance_cm, gas_reading,
    input  ready
  );

  modport sink (
    input  valid, temperature_tenths, humidity_tenths, rear_distance_cm, gas_reading,
    output ready
  );
endinterface

>>> rtl/tafr_out_if.sv
// character channel: valid/ready handshake with one ascii character and end flag
// depends on tafr_pkg
`timescale 1ns / 1ps

interface tafr_out_if;
  import tafr_pkg::*;

  logic  valid;
  logic  ready;
  char_t out_char;
  logic  frame_end;

  modport source (
    output valid, out_char, frame_end,
    input  ready
  );

  modport sink (
    input  valid, out_char, frame_end,
    output ready
  );
endinterface

>>> rtl/telemetry_ascii_framer.sv
// top level of the telemetry ascii framer
// depends on tafr_pkg, tafr_in_if, tafr_out_if, tafr_ctrl and tafr_dp
`timescale 1ns / 1ps

// usage
// - in_ch takes one item: four unsigned 16-bit readings (temperature, humidity,
//   rear distance, gas); it is taken at a clock edge with valid and ready high
// - out_ch returns the frame '<' T..,H..,R..,L0,X0,G.. '|' HH '>' CR LF one
//   character per item, frame_end set on the closing line feed
// - HH is the xor of the body characters as two uppercase hex digits
// sequence
// - after an item is taken, the bcd conversion runs in the four
//   double-dabble shifters, then a 40-slot frame template is walked one slot
//   per cycle while the output register can take a character; leading zero
//   digit slots are walked but emit nothing
// - in_ch.ready is high only while idle: one request at a time
// reset
// - synchronous active low rst_n returns the sequencer to idle and empties the
//   output register; no other state is kept between items
// stall
// - a character waits in the output register while out_ch.ready is low and
//   the template walk halts until it is taken
module telemetry_ascii_framer (
  input  logic      clk,
  input  logic      rst_n,
  tafr_in_if.sink   in_ch,
  tafr_out_if.source out_ch
);
  import tafr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  tafr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // conversion, character generation and output register
  tafr_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .temperature_tenths (in_ch.temperature_tenths),
    .humidity_tenths    (in_ch.humidity_tenths),
    .rear_distance_cm   (in_ch.rear_distance_cm),
    .gas_reading        (in_ch.gas_reading),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_char           (out_ch.out_char),
    .out_frame_end      (out_ch.frame_end)
  );

endmodule

>>> rtl/tafr_ctrl.sv
// sequencer for the framer: idle, binary to bcd conversion, character emission
// depends on tafr_pkg; drives the datapath through dp_cmd_t
`timescale 1ns / 1ps

module tafr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output tafr_pkg::dp_cmd_t  cmd,
  input  tafr_pkg::dp_stat_t stat
);
  import tafr_pkg::*;

  state_t    state_r, state_nxt;
  conv_cnt_t cnt_r, cnt_nxt;
  pos_t      pos_r, pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cnt_nxt = cnt_r + conv_cnt_t'(1);
        pos_nxt = '0;
        if (cnt_r == CONV_LAST) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          pos_nxt = pos_r + pos_t'(1);
          if (pos_r == POS_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.conv_step = 1'b0;
    cmd.emit_step = 1'b0;
    cmd.pos       = pos_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV: cmd.conv_step = 1'b1;
      ST_EMIT: cmd.emit_step = stat.out_free;
      default: in_ready = 1'b0;
    endcase
  end

  a_load_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_CONV) && (cnt_r == '0))
    else $error("load did not start conversion");

  a_conv_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) && (cnt_r == CONV_LAST) |=> (state_r == ST_EMIT) && (pos_r == '0))
    else $error("conversion did not hand over to emission at position zero");

  a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && stat.out_free && (pos_r == POS_LAST) |=> (state_r == ST_IDLE))
    else $error("frame end did not return to idle");

  a_no_step_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && !stat.out_free |=> $stable(pos_r))
    else $error("position moved while output was blocked");

endmodule

>>> rtl/tafr_dp.sv
// datapath: four double-dabble converters, frame character generator,
// running checksum and the output register; depends on tafr_pkg
`timescale 1ns / 1ps

module tafr_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  tafr_pkg::dp_cmd_t   cmd,
  output tafr_pkg::dp_stat_t  stat,
  input  tafr_pkg::val_t      temperature_tenths,
  input  tafr_pkg::val_t      humidity_tenths,
  input  tafr_pkg::val_t      rear_distance_cm,
  input  tafr_pkg::val_t      gas_reading,
  output logic                out_valid,
  input  logic                out_ready,
  output tafr_pkg::char_t     out_char,
  output logic                out_frame_end
);
  import tafr_pkg::*;

  bcd_t  bcd_r   [NUM_VALS];
  val_t  bin_r   [NUM_VALS];
  bcd_t  adj     [NUM_VALS];
  bcd_t  bcd_nxt [NUM_VALS];
  val_t  bin_nxt [NUM_VALS];
  val_t  load_val[NUM_VALS];

  logic [CHAR_W-1:0] csum_r;
  logic              out_valid_r;
  char_t             out_char_r;
  logic              out_end_r;

  slot_t             slot;
  bcd_t              sel_bcd;
  bcd_t              upper;
  logic [DIG_W-1:0]  dig_rem;
  logic [DIG_W+1:0]  shamt;
  logic              lead_ok;
  char_t             ch;
  logic              ch_emit;

  assign load_val[0] = temperature_tenths;
  assign load_val[1] = humidity_tenths;
  assign load_val[2] = rear_distance_cm;
  assign load_val[3] = gas_reading;

  // one double-dabble step per value: add-3 on digits >= 5, then shift
  always_comb begin
    for (int v = 0; v < NUM_VALS; v++) begin
      adj[v] = bcd_r[v];
      for (int d = 0; d < DEC_DIGITS; d++) begin
        if (bcd_r[v][4*d +: 4] >= 4'd5) begin
          adj[v][4*d +: 4] = bcd_r[v][4*d +: 4] + 4'd3;
        end
      end
      bcd_nxt[v] = {adj[v][BCD_W-2:0], bin_r[v][VAL_W-1]};
      bin_nxt[v] = {bin_r[v][VAL_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    for (int v = 0; v < NUM_VALS; v++) begin
      if (cmd.load) begin
        bcd_r[v] <= '0;
        bin_r[v] <= load_val[v];
      end else if (cmd.conv_step) begin
        bcd_r[v] <= bcd_nxt[v];
        bin_r[v] <= bin_nxt[v];
      end
    end
  end

  // character for the current slot; leading zero digits are dropped
  always_comb begin
    slot    = slot_info(cmd.pos);
    sel_bcd = bcd_r[slot.val_idx];
    dig_rem = DIG_W'(DEC_DIGITS - 1) - slot.dig_idx;
    shamt   = {dig_rem, 2'b00};
    upper   = sel_bcd >> shamt;
    lead_ok = (upper != '0) || (slot.dig_idx == DIG_W'(DEC_DIGITS - 1));
    ch      = slot.lit;
    ch_emit = 1'b1;
    case (slot.kind)
      SLOT_LIT: ch = slot.lit;
      SLOT_DIG: begin
        ch      = CH_0 + char_t'(upper[3:0]);
        ch_emit = lead_ok;
      end
      SLOT_CSH: ch = hex_char({1'b0, csum_r[CHAR_W-1:4]});
      SLOT_CSL: ch = hex_char(csum_r[3:0]);
      default:  ch = slot.lit;
    endcase
  end

  // running xor over body characters as they go out
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      csum_r <= '0;
    end else if (cmd.emit_step && ch_emit && slot.body) begin
      csum_r <= csum_r ^ ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_step && ch_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step && ch_emit) begin
      out_char_r <= ch;
      out_end_r  <= (cmd.pos == POS_LAST);
    end
  end

  assign stat.out_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_frame_end  = out_end_r;

endmodule

>>> bench/testbench.sv
// self-checking bench for the telemetry ascii framer: readings in, frame characters out
// depends on tafr_pkg, tafr_in_if, tafr_out_if and the telemetry_ascii_framer rtl
`timescale 1ns / 1ps

module testbench;
  import tafr_pkg::*;

  localparam int QUIET_LIMIT    = 1000;  // cycles without any handshake before giving up
  localparam int SETTLE_CYCLES  = 60;    // a bit more than one unstalled frame
  localparam int REPORT_LIMIT   = 10;
  localparam int RANDOM_ITEMS   = 460;

  // one request: four raw readings
  typedef struct {
    val_t temp;
    val_t hum;
    val_t rear;
    val_t gas;
  } reading_t;

  // one character of a frame as it should appear on out_ch
  typedef struct {
    char_t ch;
    logic  is_end;
  } frame_char_t;

  logic clk;
  logic rst_n;

  tafr_in_if  in_ch ();
  tafr_out_if out_ch ();

  telemetry_ascii_framer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // characters still owed by the block, oldest first
  frame_char_t pending_chars[$];

  int error_count;
  int quiet_cycles;
  int tx_gap_max;    // sender idles 0..tx_gap_max cycles before each item
  int rx_stall_max;  // receiver stalls 0..rx_stall_max cycles before each character

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // frame predictor
  // ---------------------------------------------------------------------------

  // appends the decimal text of v, no leading zeros, zero as a single '0'
  function automatic void add_decimal(inout char_t body[$], input val_t v);
    char_t digs[$];
    val_t  rest;
    rest = v;
    if (rest == '0) begin
      digs.push_front(CH_0);
    end
    while (rest != '0) begin
      digs.push_front(CH_0 + char_t'(rest % val_t'(10)));
      rest = rest / val_t'(10);
    end
    foreach (digs[i]) body.push_back(digs[i]);
  endfunction

  function automatic char_t nibble_hex(logic [3:0] n);
    if (n < 4'd10) begin
      return CH_0 + char_t'(n);
    end
    return CH_A + char_t'(n - 4'd10);
  endfunction

  // builds the whole expected frame for one reading and queues it
  function automatic void build_frame(reading_t r);
    char_t      body[$];
    logic [7:0] xsum;
    frame_char_t fc;
    // body: T<temp>,H<hum>,R<rear>,L0,X0,G<gas>
    body.push_back(CH_T);
    add_decimal(body, r.temp);
    body.push_back(CH_COMMA);
    body.push_back(CH_H);
    add_decimal(body, r.hum);
    body.push_back(CH_COMMA);
    body.push_back(CH_R);
    add_decimal(body, r.rear);
    body.push_back(CH_COMMA);
    body.push_back(CH_L);
    body.push_back(CH_0);
    body.push_back(CH_COMMA);
    body.push_back(CH_X);
    body.push_back(CH_0);
    body.push_back(CH_COMMA);
    body.push_back(CH_G);
    add_decimal(body, r.gas);
    xsum = '0;
    foreach (body[i]) xsum = xsum ^ {1'b0, body[i]};
    // wrap: '<' body '|' HH '>' CR LF
    body.push_front(CH_LT);
    body.push_back(CH_BAR);
    body.push_back(nibble_hex(xsum[7:4]));
    body.push_back(nibble_hex(xsum[3:0]));
    body.push_back(CH_GT);
    body.push_back(CH_CR);
    body.push_back(CH_LF);
    foreach (body[i]) begin
      fc.ch     = body[i];
      fc.is_end = (i == body.size() - 1);
      pending_chars.push_back(fc);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  function automatic reading_t make_reading(int t, int h, int d, int g);
    reading_t r;
    r.temp = val_t'(t);
    r.hum  = val_t'(h);
    r.rear = val_t'(d);
    r.gas  = val_t'(g);
    return r;
  endfunction

  // mostly values of a chosen digit count, some full-range, some zero
  function automatic val_t pick_value();
    int kind;
    int ndig;
    int lo;
    int hi;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      return val_t'($urandom_range(0, 65535));
    end
    if (kind == 3) begin
      return '0;
    end
    ndig = $urandom_range(1, 5);
    lo   = (ndig == 1) ? 1 : 10 ** (ndig - 1);
    hi   = (ndig == 5) ? 65535 : (10 ** ndig) - 1;
    return val_t'($urandom_range(hi, lo));
  endfunction

  // presents one item at the falling edge, holds it until taken, predicts its frame;
  // returns just after the falling edge that follows the accepting edge
  task automatic send_reading(reading_t r);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.temperature_tenths <= r.temp;
    in_ch.humidity_tenths    <= r.hum;
    in_ch.rear_distance_cm   <= r.rear;
    in_ch.gas_reading        <= r.gas;
    do @(posedge clk); while (!in_ch.ready);
    build_frame(r);
    @(negedge clk);
  endtask

  // drops valid and lets every owed character come out before the next item is offered
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side and checker
  // ---------------------------------------------------------------------------

  task automatic check_char(char_t got_ch, logic got_end);
    frame_char_t want;
    if (pending_chars.size() == 0) begin
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
        $display("[%0t] unexpected character 0x%02h end=%0b", $realtime, got_ch, got_end);
      end
    end else begin
      want = pending_chars.pop_front();
      if (got_ch !== want.ch || got_end !== want.is_end) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("[%0t] character mismatch: expected 0x%02h end=%0b, got 0x%02h end=%0b",
                   $realtime, want.ch, want.is_end, got_ch, got_end);
        end
      end
    end
  endtask

  // random stall before each character, then sample at the rising edge
  initial begin : char_sink
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      check_char(out_ch.out_char, out_ch.frame_end);
      @(negedge clk);
    end
  end

  // watchdog: ends the run when neither channel has moved for too long
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // all zeros, all ones, alternating bit patterns and byte halves across the fields
  task automatic test_extreme_values();
    send_reading(make_reading(0, 0, 0, 0));
    send_reading(make_reading(65535, 65535, 65535, 65535));
    send_reading(make_reading(16'hAAAA, 16'h5555, 16'hFF00, 16'h00FF));
    send_reading(make_reading(16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00));
  endtask

  // each field walks through every decimal length and its edges
  task automatic test_digit_lengths();
    int edges[10] = '{1, 9, 10, 99, 100, 999, 1000, 9999, 10000, 65535};
    foreach (edges[i]) begin
      send_reading(make_reading(edges[i], edges[i], edges[i], edges[i]));
    end
  endtask

  // fields of different lengths side by side, so digit skipping differs per field
  task automatic test_mixed_widths();
    send_reading(make_reading(0, 65535, 12345, 9));
    send_reading(make_reading(10000, 0, 99, 65535));
    send_reading(make_reading(7, 4321, 0, 100));
    send_reading(make_reading(65535, 1, 65535, 0));
    send_reading(make_reading(250, 655, 3, 40960));
  endtask

  // long random run in phases: full idling, none, receiver only, sender only;
  // halfway through each phase the sender holds off until every owed character has come
  task automatic test_random_frames();
    int phase_len;
    reading_t r;
    phase_len = RANDOM_ITEMS / 4;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          tx_gap_max   = 19;
          rx_stall_max = 19;
        end
        1: begin
          tx_gap_max   = 0;
          rx_stall_max = 0;
        end
        2: begin
          tx_gap_max   = 0;
          rx_stall_max = 19;
        end
        default: begin
          tx_gap_max   = 19;
          rx_stall_max = 0;
        end
      endcase
      for (int n = 0; n < phase_len; n++) begin
        r.temp = pick_value();
        r.hum  = pick_value();
        r.rear = pick_value();
        r.gas  = pick_value();
        send_reading(r);
        // quiet point in the middle of the phase
        if (n == phase_len / 2) begin
          wait_for_drain();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    error_count              = 0;
    tx_gap_max               = 19;
    rx_stall_max             = 19;
    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.temperature_tenths = '0;
    in_ch.humidity_tenths    = '0;
    in_ch.rear_distance_cm   = '0;
    in_ch.gas_reading        = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_extreme_values();
    test_digit_lengths();
    test_mixed_widths();
    test_random_frames();

    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    // anything beyond the last frame would show up here as unexpected
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      error_count++;
      $display("%0d characters never arrived", pending_chars.size());
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tafr_pkg.sv
rtl/tafr_in_if.sv
rtl/tafr_out_if.sv
rtl/tafr_ctrl.sv
rtl/tafr_dp.sv
rtl/telemetry_ascii_framer.sv
bench/testbench.sv
